FILE: src/ircstrip_pkg.sv
// Shared types and constants for the IRC control code stripper.
// No dependencies; used by irc_control_code_stripper_top.
`timescale 1ns / 1ps
`default_nettype none

package ircstrip_pkg;

   // Byte codes that steer the color sequence
   localparam logic [7:0] COLOR_BYTE = 8'd3;
   localparam logic [7:0] COMMA_BYTE = 8'd44;
   localparam logic [7:0] FIRST_KEPT = 8'd32;
   localparam logic [7:0] DIGIT_LO   = 8'd48;
   localparam logic [7:0] DIGIT_HI   = 8'd57;

   // Color sequence phase, one-hot
   typedef enum logic [5:0] {
      PH_PLAIN = 6'b000001,   // ordinary text
      PH_COLOR = 6'b000010,   // color byte seen
      PH_FG1   = 6'b000100,   // one foreground digit taken
      PH_FG2   = 6'b001000,   // two foreground digits taken
      PH_COMMA = 6'b010000,   // comma taken
      PH_BG1   = 6'b100000    // one background digit taken
   } phase_type;

endpackage

`default_nettype wire

FILE: src/irc_control_code_stripper_top.sv
// A kept byte passes through the input register and then the result register to rsp_.
// Throughput: one byte per clock except when a full result register stalls;
// the input and result registers advance together, and the phase register
// updates once per byte. A byte that is dropped produces no rsp_ beat.
// Reset (synchronous, active high) empties both registers and returns the
// color phase to plain text.
`timescale 1ns / 1ps
`default_nettype none

module irc_control_code_stripper_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_text_byte,
   input  wire logic       req_starts_text,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_kept_byte
);

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_starts_ff;

   // Phase and result register
   ircstrip_pkg::phase_type phase_ff, phase_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff;

   logic       is_digit;
   logic       is_comma;
   logic       swallow;
   logic       keep;
   logic       advance;
   ircstrip_pkg::phase_type cur_phase;
   ircstrip_pkg::phase_type seq_phase;

   // Classify the byte in the input register
   assign is_digit = (in_byte_ff >= ircstrip_pkg::DIGIT_LO) &&
                     (in_byte_ff <= ircstrip_pkg::DIGIT_HI);
   assign is_comma = (in_byte_ff == ircstrip_pkg::COMMA_BYTE);
   assign cur_phase = in_starts_ff ? ircstrip_pkg::PH_PLAIN : phase_ff;

   // Color sequence step; a byte that does not fit falls back to plain text
   always_comb begin
      swallow   = 1'b0;
      seq_phase = ircstrip_pkg::PH_PLAIN;
      case (cur_phase)
         ircstrip_pkg::PH_COLOR: begin
            if (is_digit) begin
               swallow   = 1'b1;
               seq_phase = ircstrip_pkg::PH_FG1;
            end
         end
         ircstrip_pkg::PH_FG1: begin
            if (is_digit) begin
               swallow   = 1'b1;
               seq_phase = ircstrip_pkg::PH_FG2;
            end else if (is_comma) begin
               swallow   = 1'b1;
               seq_phase = ircstrip_pkg::PH_COMMA;
            end
         end
         ircstrip_pkg::PH_FG2: begin
            if (is_comma) begin
               swallow   = 1'b1;
               seq_phase = ircstrip_pkg::PH_COMMA;
            end
         end
         ircstrip_pkg::PH_COMMA: begin
            if (is_digit) begin
               swallow   = 1'b1;
               seq_phase = ircstrip_pkg::PH_BG1;
            end
         end
         ircstrip_pkg::PH_BG1: begin
            // second background digit closes the sequence
            if (is_digit) begin
               swallow   = 1'b1;
               seq_phase = ircstrip_pkg::PH_PLAIN;
            end
         end
         default: begin
            swallow   = 1'b0;
            seq_phase = ircstrip_pkg::PH_PLAIN;
         end
      endcase
   end

   // Plain text handling when the sequence did not take the byte
   always_comb begin
      keep     = 1'b0;
      phase_in = phase_ff;
      if (swallow) begin
         phase_in = seq_phase;
      end else if (in_byte_ff == ircstrip_pkg::COLOR_BYTE) begin
         phase_in = ircstrip_pkg::PH_COLOR;
      end else begin
         phase_in = ircstrip_pkg::PH_PLAIN;
         keep     = (in_byte_ff >= ircstrip_pkg::FIRST_KEPT);
      end
   end

   // Input beat moves on unless it must land in a full, stalled result register
   assign advance      = in_valid_ff && (!keep || !out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = req_valid ? 1'b1 : (in_valid_ff && !advance);
   assign out_valid_in = (advance && keep) ? 1'b1 : (out_valid_ff && !rsp_ready);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= ircstrip_pkg::PH_PLAIN;
      end else begin
         if (req_ready) begin
            in_valid_ff <= in_valid_in;
         end
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff   <= req_text_byte;
         in_starts_ff <= req_starts_text;
      end
      if (advance && keep) begin
         out_byte_ff <= in_byte_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_kept_byte = out_byte_ff;

   // A kept byte is never a control byte
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_byte_ff >= ircstrip_pkg::FIRST_KEPT))
      else $error("control byte reached the result register");

   // Phase register stays one-hot
   assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("color phase is not one-hot");

   // The input register only stalls behind a full, stalled result register
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |-> (out_valid_ff && !rsp_ready && keep))
      else $error("input stalled without a result back-pressure");

   // A dropped byte never produces a new result beat
   assert property (@(posedge clock) disable iff (reset)
      (advance && !keep && !out_valid_ff) |=> !out_valid_ff)
      else $error("dropped byte produced a result");

endmodule

`default_nettype wire

FILE: verif/irc_control_code_stripper_top_test.sv
// Testbench for irc_control_code_stripper_top: streams text bytes through the
// stripper and checks every kept byte against an in-bench predictor.
// Depends on src/ircstrip_pkg.sv and src/irc_control_code_stripper_top.sv.
`timescale 1ns / 1ps

module irc_control_code_stripper_top_test;

   localparam int QUIET_LIMIT = 2000;   // cycles with no beat before giving up
   localparam int HOLD_CYCLES = 150;    // long receiver hold-off
   localparam int DRAIN_CYCLES = 10;    // settle time after the last result

   typedef struct packed {
      logic [7:0] text_byte;
      logic       starts_text;
   } text_item_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_text_byte = 8'd0;
   logic       req_starts_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_kept_byte;

   text_item_type pending[$];
   logic [7:0] kept_expected[$];
   ircstrip_pkg::phase_type color_phase = ircstrip_pkg::PH_PLAIN;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_arm = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;
   int fail_count = 0;
   int quiet_cycles = 0;

   irc_control_code_stripper_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_text_byte   (req_text_byte),
      .req_starts_text (req_starts_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kept_byte   (rsp_kept_byte)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit is_digit(input logic [7:0] b);
      return b >= ircstrip_pkg::DIGIT_LO && b <= ircstrip_pkg::DIGIT_HI;
   endfunction

   // Advance the color phase for one byte; queue the byte if it survives
   function automatic void strip_predict(input logic [7:0] b, input logic starts);
      ircstrip_pkg::phase_type ph;
      bit                      swallow;
      ph = starts ? ircstrip_pkg::PH_PLAIN : color_phase;
      swallow = 1'b0;
      case (ph)
         ircstrip_pkg::PH_COLOR: begin
            if (is_digit(b)) begin
               color_phase = ircstrip_pkg::PH_FG1;
               swallow = 1'b1;
            end
         end
         ircstrip_pkg::PH_FG1: begin
            if (is_digit(b)) begin
               color_phase = ircstrip_pkg::PH_FG2;
               swallow = 1'b1;
            end else if (b == ircstrip_pkg::COMMA_BYTE) begin
               color_phase = ircstrip_pkg::PH_COMMA;
               swallow = 1'b1;
            end
         end
         ircstrip_pkg::PH_FG2: begin
            if (b == ircstrip_pkg::COMMA_BYTE) begin
               color_phase = ircstrip_pkg::PH_COMMA;
               swallow = 1'b1;
            end
         end
         ircstrip_pkg::PH_COMMA: begin
            if (is_digit(b)) begin
               color_phase = ircstrip_pkg::PH_BG1;
               swallow = 1'b1;
            end
         end
         ircstrip_pkg::PH_BG1: begin
            if (is_digit(b)) begin
               color_phase = ircstrip_pkg::PH_PLAIN;
               swallow = 1'b1;
            end
         end
         default: ;
      endcase
      // a byte that breaks the sequence is ordinary text
      if (!swallow) begin
         if (b == ircstrip_pkg::COLOR_BYTE) begin
            color_phase = ircstrip_pkg::PH_COLOR;
         end else begin
            color_phase = ircstrip_pkg::PH_PLAIN;
            if (b >= ircstrip_pkg::FIRST_KEPT) kept_expected.push_back(b);
         end
      end
   endfunction

   // Driver: next beat goes out once the current one is taken
   always @(posedge clock) begin : drive_beats
      text_item_type beat;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            beat = pending.pop_front();
            req_valid <= 1'b1;
            req_text_byte <= beat.text_byte;
            req_starts_text <= beat.starts_text;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver ready: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_arm && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: predict on input beats, compare on result beats
   always @(posedge clock) begin : watch_beats
      logic [7:0] want;
      if (!reset) begin
         if (req_valid && req_ready) strip_predict(req_text_byte, req_starts_text);
         if (rsp_valid && rsp_ready) begin
            if (kept_expected.size() == 0) begin
               $error("kept_byte: expected none, actual %0d", rsp_kept_byte);
               fail_count++;
            end else begin
               want = kept_expected.pop_front();
               if (rsp_kept_byte !== want) begin
                  $error("kept_byte: expected %0d, actual %0d", want, rsp_kept_byte);
                  fail_count++;
               end
            end
         end
      end
   end

   // Watchdog on stretches with no beat on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic add_item(input logic [7:0] b, input logic starts);
      text_item_type it;
      it.text_byte = b;
      it.starts_text = starts;
      pending.push_back(it);
   endtask

   // Byte with an occasional start-of-text mark
   task automatic add_byte(input logic [7:0] b);
      add_item(b, $urandom_range(99) < 4);
   endtask

   task automatic add_digits(input int n);
      for (int i = 0; i < n; i++) begin
         add_byte(8'($urandom_range(ircstrip_pkg::DIGIT_LO, ircstrip_pkg::DIGIT_HI)));
      end
   endtask

   // Mostly well-formed color sequences and text, some noise
   task automatic fill_random(input int n);
      int start_size;
      int kind;
      int fg;
      start_size = pending.size();
      while (pending.size() - start_size < n) begin
         kind = $urandom_range(99);
         if (kind < 40) begin
            add_byte(ircstrip_pkg::COLOR_BYTE);
            fg = $urandom_range(2);
            add_digits(fg);
            if (fg > 0 && $urandom_range(3) != 0) begin
               add_byte(ircstrip_pkg::COMMA_BYTE);
               add_digits($urandom_range(2));
            end
            add_byte(8'($urandom_range(32, 126)));
         end else if (kind < 70) begin
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(32, 126)));
         end else if (kind < 80) begin
            add_byte(8'($urandom_range(0, 31)));
         end else if (kind < 92) begin
            add_byte(8'($urandom_range(0, 255)));
         end else if ($urandom_range(1) != 0) begin
            add_byte(ircstrip_pkg::COMMA_BYTE);
         end else begin
            add_digits(1);
         end
      end
   endtask

   // Sender pause: hold until every queued beat and result is through
   task automatic wait_drained();
      while (pending.size() != 0 || req_valid || kept_expected.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: field extremes, control bytes, high bytes
      send_idle_pct = 34;
      recv_idle_pct = 62;
      add_item(8'd0, 1'b1);
      add_item(8'd255, 1'b0);
      add_item(8'd31, 1'b0);
      add_item(8'd32, 1'b0);
      add_item(8'd127, 1'b0);
      add_item(8'd128, 1'b0);
      // full sequence, then a third digit that is kept
      add_item(ircstrip_pkg::COLOR_BYTE, 1'b0);
      add_item("1", 1'b0);
      add_item("2", 1'b0);
      add_item(ircstrip_pkg::COMMA_BYTE, 1'b0);
      add_item("3", 1'b0);
      add_item("4", 1'b0);
      add_item("5", 1'b0);
      // comma with no digit before it is kept
      add_item(ircstrip_pkg::COLOR_BYTE, 1'b0);
      add_item(ircstrip_pkg::COMMA_BYTE, 1'b0);
      // comma swallowed with no background digit
      add_item(ircstrip_pkg::COLOR_BYTE, 1'b0);
      add_item("7", 1'b0);
      add_item(ircstrip_pkg::COMMA_BYTE, 1'b0);
      add_item("A", 1'b0);
      // color byte inside a sequence restarts it
      add_item(ircstrip_pkg::COLOR_BYTE, 1'b0);
      add_item("1", 1'b0);
      add_item(ircstrip_pkg::COLOR_BYTE, 1'b0);
      add_item("9", 1'b0);
      // start-of-text cuts a pending sequence
      add_item(ircstrip_pkg::COLOR_BYTE, 1'b0);
      add_item("8", 1'b1);
      fill_random(300);
      wait_drained();

      send_idle_pct = 62;
      recv_idle_pct = 34;
      fill_random(300);
      wait_drained();

      // no idling; the long receiver hold lands here
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_arm = 1'b1;
      fill_random(300);
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0 && kept_expected.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
